// ----- hw/rtl/sqmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared constants, types and helpers of the square matrix multiplier.
// ----------------------------------------------------------------------------
package sqmm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W     = $clog2(MAX_DIM + 1);
	localparam int DRAIN_LEN = MAX_DIM + 2;
	localparam int DRN_W     = $clog2(DRAIN_LEN + 1);
	localparam int WORD_W    = 32;
	localparam int DIM_W     = 4;
	localparam int FLD_W     = 3;

	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_START  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              v;
		logic              first;
		logic [IDX_W-1:0]  k;
		logic [WORD_W-1:0] a;
	} cell_bus_t;

	typedef struct packed {
		logic capture;
		logic shift;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] act_dim(input logic [DIM_W-1:0] d);
		logic [CNT_W-1:0] n;
		if (d == '0)
			n = CNT_W'(1);
		else if (32'(d) > MAX_DIM)
			n = CNT_W'(MAX_DIM);
		else
			n = CNT_W'(d);
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sqmm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_cell
// One column cell: holds its column of B, multiplies the passing A element,
// accumulates one product element and shifts results toward the row head.
// ----------------------------------------------------------------------------
module sqmm_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         b_we,
	input  wire logic [sqmm_pkg::IDX_W-1:0]   b_addr,
	input  wire logic [sqmm_pkg::WORD_W-1:0]  b_wdata,
	input  wire sqmm_pkg::cell_bus_t          bus_in,
	output sqmm_pkg::cell_bus_t               bus_out,
	input  wire sqmm_pkg::cell_ctl_t          ctl,
	input  wire logic [sqmm_pkg::WORD_W-1:0]  res_in,
	output logic [sqmm_pkg::WORD_W-1:0]       res_out
);
	import sqmm_pkg::*;

	logic [WORD_W-1:0] b_mem [MAX_DIM];
	logic [WORD_W-1:0] prod_s1;
	logic              v_s1;
	logic              first_s1;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] res_q;
	cell_bus_t         bus_q;

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[b_addr] <= b_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q    <= '0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			bus_q    <= bus_in;
			v_s1     <= bus_in.v;
			first_s1 <= bus_in.first;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= WORD_W'(bus_in.a * b_mem[bus_in.k]);
		if (v_s1)
			acc_q <= first_s1 ? prod_s1 : acc_q + prod_s1;
		if (ctl.capture)
			res_q <= acc_q;
		else if (ctl.shift)
			res_q <= res_in;
	end

	assign bus_out = bus_q;
	assign res_out = res_q;

endmodule
`default_nettype wire

// ----- hw/rtl/square_integer_matrix_multiply_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_integer_matrix_multiply_top
// Square signed 32-bit matrix multiplier built as a row of column cells.
//
// Input channel (in_valid / in_stall): a beat with req_type load A or load B
// writes one element at elem_row / elem_col; writes outside the store are
// dropped. A start beat runs C = A * B over the leading n x n corner, where n
// is the dim register (0 reads as 1, above 8 as 8). Unused codes are dropped.
// Loads are taken while idle; in_stall is high for the whole of a start run.
// Output channel (out_valid / out_stall): one beat per element of C in
// row-major order, last high on the final one. Values wrap modulo 2^32.
// Each output row is fed from A, then drained while the A elements pass
// all cells and the multiply-accumulate settles, then emitted; the run
// then feeds the next row or, after the last one, returns to idle.
// The single output register holds its beat while out_stall is high and
// the run pauses behind it.
// dim is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce it.
// Reset returns dim to 8 and control to idle; A and B contents are undefined
// until loaded, and every entry inside n must be loaded before start.
// ----------------------------------------------------------------------------
module square_integer_matrix_multiply_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sqmm_pkg::DIM_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [sqmm_pkg::FLD_W-1:0]    elem_row,
	input  wire logic [sqmm_pkg::FLD_W-1:0]    elem_col,
	input  wire logic signed [31:0]            elem_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [31:0]                 prod_value,
	output logic [sqmm_pkg::FLD_W-1:0]         prod_row,
	output logic [sqmm_pkg::FLD_W-1:0]         prod_col,
	output logic                               last
);
	import sqmm_pkg::*;

	state_t            state_q, state_d;
	logic [DIM_W-1:0]  dim_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  n_m1;
	logic [IDX_W-1:0]  row_q, k_q, col_q;
	logic [DRN_W-1:0]  drain_q;

	logic              in_acc;
	logic              in_range;
	logic              feed_v;
	logic              emit_go;
	logic              drain_done;
	cell_ctl_t         ctl;

	logic [WORD_W-1:0] a_mem [MAX_DIM << IDX_W];
	logic [WORD_W-1:0] a_rd_s1;
	logic              a_v_s1;
	logic              a_first_s1;
	logic [IDX_W-1:0]  a_k_s1;

	cell_bus_t         bus [MAX_DIM+1];
	logic [WORD_W-1:0] res [MAX_DIM+1];

	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic [FLD_W-1:0]  out_row_q, out_col_q;
	logic              out_last_q;

	assign in_acc     = in_valid && !in_stall;
	assign in_range   = (32'(elem_row) < MAX_DIM) && (32'(elem_col) < MAX_DIM);
	assign n_m1       = IDX_W'(n_q - CNT_W'(1));
	assign drain_done = (32'(drain_q) == DRAIN_LEN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dim_q <= DIM_W'(MAX_DIM);
		else if (cfg_we)
			dim_q <= cfg_wdata;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && req_type == REQ_START)
					state_d = ST_FEED;
			end
			ST_FEED: begin
				if (k_q == n_m1)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go && col_q == n_m1)
					state_d = (row_q == n_m1) ? ST_IDLE : ST_FEED;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		feed_v      = 1'b0;
		ctl.capture = 1'b0;
		emit_go     = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall    = 1'b0;
			ST_FEED:  feed_v      = 1'b1;
			ST_DRAIN: ctl.capture = drain_done;
			ST_EMIT:  emit_go     = !out_valid_q || !out_stall;
			default:  in_stall    = 1'b1;
		endcase
		ctl.shift = emit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= CNT_W'(MAX_DIM);
			row_q   <= '0;
			k_q     <= '0;
			col_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && req_type == REQ_START) begin
				n_q   <= act_dim(dim_q);
				row_q <= '0;
				k_q   <= '0;
			end
			if (feed_v)
				k_q <= (k_q == n_m1) ? '0 : k_q + IDX_W'(1);
			if (state_q == ST_DRAIN)
				drain_q <= drain_done ? '0 : drain_q + DRN_W'(1);
			if (ctl.capture)
				col_q <= '0;
			if (emit_go) begin
				col_q <= col_q + IDX_W'(1);
				if (col_q == n_m1)
					row_q <= row_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_LOAD_A && in_range)
			a_mem[{elem_row[IDX_W-1:0], elem_col[IDX_W-1:0]}] <= elem_value;
		a_rd_s1    <= a_mem[{row_q, k_q}];
		a_k_s1     <= k_q;
		a_first_s1 <= (k_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			a_v_s1 <= 1'b0;
		else
			a_v_s1 <= feed_v;
	end

	assign bus[0].v     = a_v_s1;
	assign bus[0].first = a_first_s1;
	assign bus[0].k     = a_k_s1;
	assign bus[0].a     = a_rd_s1;
	assign res[MAX_DIM] = '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		logic b_we;
		assign b_we = in_acc && req_type == REQ_LOAD_B && in_range
			&& (32'(elem_col) == j);
		sqmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.b_we    (b_we),
			.b_addr  (elem_row[IDX_W-1:0]),
			.b_wdata (elem_value),
			.bus_in  (bus[j]),
			.bus_out (bus[j+1]),
			.ctl     (ctl),
			.res_in  (res[j+1]),
			.res_out (res[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_value_q <= res[0];
			out_row_q   <= FLD_W'(row_q);
			out_col_q   <= FLD_W'(col_q);
			out_last_q  <= (row_q == n_m1) && (col_q == n_m1);
		end
	end

	assign out_valid  = out_valid_q;
	assign prod_value = out_value_q;
	assign prod_row   = out_row_q;
	assign prod_col   = out_col_q;
	assign last       = out_last_q;

	a_feed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEED) |-> (k_q <= n_m1))
		else $error("feed index beyond active size");

	a_capture_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == ST_EMIT) && (col_q == '0))
		else $error("capture not followed by emit from column zero");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_row_q == out_col_q))
		else $error("last beat off the diagonal corner");

	a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit_go)
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
